@@ src/dmf_pkg.sv @@
// Package for the max-flow engine: payload structs, controller states,
// command and status bundles, and shared constants. No dependencies.
package dmf_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_NODES_DEF = 256;
	localparam int MAX_EDGES_DEF = 512;

	// Fixed field widths
	localparam int NODE_W = 8;
	localparam int CAP_W  = 31;
	localparam int FLOW_W = 39;

	localparam logic [NODE_W-1:0] SINK_RESET  = 8'd2;
	localparam logic [CAP_W-1:0]  PASS_BUDGET = 31'h3f3f3f3f;
	localparam int                SOURCE_NODE = 1;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_SOLVE = 1'b1;

	typedef struct packed {
		logic              command;
		logic [NODE_W-1:0] from_node;
		logic [NODE_W-1:0] to_node;
		logic [CAP_W-1:0]  capacity;
	} in_item_t;

	typedef struct packed {
		logic [FLOW_W-1:0] max_flow;
		logic              edges_dropped;
	} out_item_t;

	typedef enum logic [19:0] {
		ST_IDLE     = 20'h00001,
		ST_ADD1     = 20'h00002,
		ST_ADD2     = 20'h00004,
		ST_SOLVE    = 20'h00008,
		ST_BFS_CLR  = 20'h00010,
		ST_BFS_POP  = 20'h00020,
		ST_BFS_U    = 20'h00040,
		ST_BFS_E    = 20'h00080,
		ST_BFS_V    = 20'h00100,
		ST_BFS_CHK  = 20'h00200,
		ST_DFS_INIT = 20'h00400,
		ST_DFS_TOP  = 20'h00800,
		ST_DFS_EDGE = 20'h01000,
		ST_DFS_LVL  = 20'h02000,
		ST_PUSH2    = 20'h04000,
		ST_POP2     = 20'h08000,
		ST_CR_A     = 20'h10000,
		ST_CR_B     = 20'h20000,
		ST_CR_C     = 20'h40000,
		ST_DONE     = 20'h80000
	} state_t;

	typedef struct packed {
		state_t st;
	} ctl_cmd_t;

	typedef struct packed {
		logic sink_ok;
		logic sweep_last;
		logic q_empty;
		logic e_none;
		logic found;
		logic next_none;
		logic pop;
		logic last_frame;
		logic admit;
		logic to_sink;
		logic can_push;
		logic out_free;
	} dp_sts_t;

endpackage

@@ src/dmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ src/dmf_ctrl.sv @@
// Controller state machine: sequences edge loading, level build and the
// blocking-flow walk from datapath status. Depends on dmf_pkg.
module dmf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_command,
	input  dmf_pkg::dp_sts_t sts,
	output dmf_pkg::ctl_cmd_t cmd,
	output logic             in_stall
);
	import dmf_pkg::*;

	state_t state_q, state_nx;

	// Next-state logic
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = (in_command == CMD_SOLVE) ? ST_SOLVE : ST_ADD1;
			end
			ST_ADD1:     state_nx = ST_ADD2;
			ST_ADD2:     state_nx = ST_IDLE;
			ST_SOLVE:    state_nx = sts.sink_ok ? ST_BFS_CLR : ST_DONE;
			ST_BFS_CLR:  if (sts.sweep_last) state_nx = ST_BFS_POP;
			ST_BFS_POP:  state_nx = sts.q_empty ? ST_DONE : ST_BFS_U;
			ST_BFS_U:    state_nx = ST_BFS_E;
			ST_BFS_E:    state_nx = sts.e_none ? ST_BFS_POP : ST_BFS_V;
			ST_BFS_V:    state_nx = ST_BFS_CHK;
			ST_BFS_CHK: begin
				if (sts.found) state_nx = ST_DFS_INIT;
				else if (sts.next_none) state_nx = ST_BFS_POP;
				else state_nx = ST_BFS_V;
			end
			ST_DFS_INIT: state_nx = ST_PUSH2;
			ST_PUSH2:    state_nx = ST_DFS_TOP;
			ST_DFS_TOP: begin
				if (sts.pop) state_nx = sts.last_frame ? ST_BFS_CLR : ST_POP2;
				else state_nx = ST_DFS_EDGE;
			end
			ST_DFS_EDGE: state_nx = ST_DFS_LVL;
			ST_DFS_LVL: begin
				if (sts.admit && sts.to_sink) state_nx = ST_CR_A;
				else if (sts.admit && sts.can_push) state_nx = ST_PUSH2;
				else state_nx = ST_DFS_TOP;
			end
			ST_POP2:     state_nx = ST_CR_A;
			ST_CR_A:     state_nx = ST_CR_B;
			ST_CR_B:     state_nx = ST_CR_C;
			ST_CR_C:     state_nx = ST_DFS_TOP;
			ST_DONE:     if (sts.out_free) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign cmd.st   = state_q;
	assign in_stall = (state_q != ST_IDLE);
endmodule

@@ src/dmf_dpath.sv @@
// Datapath: edge, node, level, queue and frame memories plus the walk
// registers and result register. Depends on dmf_pkg and dmf_ram.
module dmf_dpath #(
	parameter int MAX_NODES = dmf_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = dmf_pkg::MAX_EDGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dmf_pkg::ctl_cmd_t            cmd,
	input  logic                         in_valid,
	input  dmf_pkg::in_item_t            in_data,
	input  logic                         cfg_we,
	input  logic [dmf_pkg::NODE_W-1:0]   cfg_data,
	input  logic                         out_stall,
	output logic                         out_valid,
	output dmf_pkg::out_item_t           out_data,
	output dmf_pkg::dp_sts_t             sts
);
	import dmf_pkg::*;

	localparam int NW  = $clog2(MAX_NODES);
	localparam int DW  = $clog2(MAX_NODES + 1);
	localparam int LW  = NW + 1;
	localparam int EW  = $clog2(MAX_EDGES);
	localparam int EPW = $clog2(MAX_EDGES + 1);

	localparam logic [EPW-1:0] NO_EDGE  = EPW'(MAX_EDGES);
	localparam logic [LW-1:0]  LVL_NONE = '1;
	localparam logic [NW-1:0]  SRC      = NW'(SOURCE_NODE);

	state_t st;
	assign st = cmd.st;

	// Control registers
	logic [NODE_W-1:0]    sink_q;
	logic [EPW-1:0]       cnt_q;
	logic                 drop_q;
	logic [MAX_NODES-1:0] vld_q;
	logic                 vld_rd_q;
	logic [DW-1:0]        sw_q, head_q, tail_q, depth_q;
	logic                 out_valid_q;

	// Payload registers
	logic [NW-1:0]     x_q, y_q, v_q, f_node_q;
	logic [CAP_W-1:0]  cap_q, rc_q, f_flow_q, f_res_q, amt_q;
	logic              ok_q;
	logic [LW-1:0]     lvl_u_q;
	logic [EPW-1:0]    link_q, f_edge_q;
	logic [FLOW_W-1:0] total_q;
	out_item_t         out_q;

	// Memory ports
	logic           nf_we;
	logic [NW-1:0]  nf_waddr, nf_raddr;
	logic [EPW-1:0] nf_wd, nf_rd;
	logic           e_we;
	logic [EW-1:0]  e_waddr, e_raddr;
	logic [NW-1:0]  tgt_wd, tgt_rd;
	logic [EPW-1:0] link_wd, link_rd;
	logic           r_we;
	logic [EW-1:0]  r_waddr, r_raddr;
	logic [CAP_W-1:0] r_wd, r_rd;
	logic           lv_we;
	logic [NW-1:0]  lv_waddr, lv_raddr;
	logic [LW-1:0]  lv_wd, lv_rd;
	logic           q_we;
	logic [NW-1:0]  q_waddr, q_raddr, q_wd, q_rd;
	logic           fr_we;
	logic [NW-1:0]  fr_waddr, fr_raddr;
	logic [NW+EPW-1:0]  fpos_rd;
	logic [2*CAP_W-1:0] famt_rd;

	// Derived values
	logic [EPW-1:0]   first_eff;
	logic [CAP_W-1:0] amt;
	logic [NW-1:0]    sink_idx;
	logic             lvl_set, accept, add_ok;
	logic [FLOW_W:0]  total_sum;

	assign first_eff = vld_rd_q ? nf_rd : NO_EDGE;
	assign amt       = (rc_q < f_flow_q) ? rc_q : f_flow_q;
	assign sink_idx  = NW'(sink_q);
	assign lvl_set   = (rc_q != '0) && (lv_rd == LVL_NONE);
	assign accept    = (st == ST_IDLE) && in_valid;
	assign total_sum = {1'b0, total_q} + (FLOW_W + 1)'(f_res_q);

	assign add_ok = (in_data.from_node != '0) && (in_data.from_node <= sink_q) &&
		(32'(in_data.from_node) < MAX_NODES) &&
		(in_data.to_node != '0) && (in_data.to_node <= sink_q) &&
		(32'(in_data.to_node) < MAX_NODES) &&
		((32'(cnt_q) + 32'd2) <= MAX_EDGES);

	// Status to the controller
	always_comb begin
		sts.sink_ok    = (sink_q >= 8'd2) && (32'(sink_q) < MAX_NODES);
		sts.sweep_last = (sw_q == DW'(MAX_NODES - 1));
		sts.q_empty    = (head_q == tail_q);
		sts.e_none     = (first_eff >= NO_EDGE);
		sts.found      = lvl_set && (v_q == sink_idx);
		sts.next_none  = (link_q >= NO_EDGE);
		sts.pop        = (f_edge_q >= NO_EDGE) || (f_flow_q == '0);
		sts.last_frame = (depth_q == DW'(1));
		sts.admit      = (rc_q != '0) && (lv_rd == LW'(depth_q));
		sts.to_sink    = (v_q == sink_idx);
		sts.can_push   = (32'(depth_q) < MAX_NODES);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// Memory address and write muxing
	always_comb begin
		nf_we = 1'b0; nf_waddr = x_q; nf_wd = cnt_q; nf_raddr = '0;
		e_we = 1'b0; e_waddr = EW'(cnt_q); tgt_wd = y_q; link_wd = first_eff; e_raddr = '0;
		r_we = 1'b0; r_waddr = EW'(cnt_q); r_wd = cap_q;
		lv_we = 1'b0; lv_waddr = v_q; lv_wd = lvl_u_q + LW'(1); lv_raddr = '0;
		q_we = 1'b0; q_waddr = NW'(tail_q); q_wd = v_q; q_raddr = NW'(head_q);
		fr_we = 1'b0; fr_waddr = NW'(depth_q - DW'(1)); fr_raddr = NW'(depth_q - DW'(2));
		unique case (st)
			ST_IDLE: nf_raddr = NW'(in_data.from_node);
			ST_ADD1: begin
				// forward edge at the current count, pushed on the tail's list
				nf_we = ok_q; nf_raddr = y_q;
				e_we = ok_q; r_we = ok_q;
			end
			ST_ADD2: begin
				// reverse edge, pushed on the head's list
				nf_we = ok_q; nf_waddr = y_q; nf_wd = cnt_q + EPW'(1);
				e_we = ok_q; e_waddr = EW'(cnt_q + EPW'(1)); tgt_wd = x_q;
				link_wd = (x_q == y_q) ? cnt_q : first_eff;
				r_we = ok_q; r_waddr = EW'(cnt_q + EPW'(1)); r_wd = '0;
			end
			ST_BFS_CLR: begin
				lv_we = 1'b1; lv_waddr = NW'(sw_q);
				lv_wd = (NW'(sw_q) == SRC) ? '0 : LVL_NONE;
				q_we = sts.sweep_last; q_waddr = '0; q_wd = SRC;
			end
			ST_BFS_U: begin
				nf_raddr = q_rd; lv_raddr = q_rd;
			end
			ST_BFS_E:    e_raddr = EW'(first_eff);
			ST_BFS_V:    lv_raddr = tgt_rd;
			ST_BFS_CHK: begin
				e_raddr = EW'(link_q);
				lv_we = lvl_set;
				q_we = lvl_set && !sts.found && (32'(tail_q) < MAX_NODES);
			end
			ST_DFS_INIT: nf_raddr = SRC;
			ST_DFS_TOP: begin
				e_raddr = EW'(f_edge_q);
				// dead end: drop the node from the level graph
				lv_we = sts.pop && (f_res_q == '0); lv_waddr = f_node_q; lv_wd = LVL_NONE;
			end
			ST_DFS_EDGE: lv_raddr = tgt_rd;
			ST_DFS_LVL: begin
				nf_raddr = v_q;
				fr_we = sts.admit && !sts.to_sink && sts.can_push;
			end
			ST_CR_A:     e_raddr = EW'(f_edge_q);
			ST_CR_B: begin
				r_we = (amt_q != '0); r_waddr = EW'(f_edge_q); r_wd = r_rd - amt_q;
				e_raddr = EW'(f_edge_q ^ EPW'(1));
			end
			ST_CR_C: begin
				r_we = (amt_q != '0); r_waddr = EW'(f_edge_q ^ EPW'(1)); r_wd = r_rd + amt_q;
			end
			default: ;
		endcase
		r_raddr = e_raddr;
	end

	// Control state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_q      <= SINK_RESET;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			vld_q       <= '0;
			vld_rd_q    <= 1'b0;
			sw_q        <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) sink_q <= cfg_data;
			vld_rd_q <= vld_q[nf_raddr];
			sw_q <= (st == ST_BFS_CLR) ? sw_q + DW'(1) : '0;
			// result register handshake
			if ((st == ST_DONE) && sts.out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st)
				ST_ADD1: if (ok_q) vld_q[x_q] <= 1'b1;
				ST_ADD2: begin
					if (ok_q) begin
						vld_q[y_q] <= 1'b1;
						cnt_q <= cnt_q + EPW'(2);
					end else begin
						drop_q <= 1'b1;
					end
				end
				ST_BFS_CLR: begin
					head_q <= '0;
					tail_q <= DW'(1);
				end
				ST_BFS_POP: if (!sts.q_empty) head_q <= head_q + DW'(1);
				ST_BFS_CHK: if (q_we) tail_q <= tail_q + DW'(1);
				ST_DFS_INIT: depth_q <= DW'(1);
				ST_DFS_LVL: if (fr_we) depth_q <= depth_q + DW'(1);
				ST_POP2: depth_q <= depth_q - DW'(1);
				ST_DONE: begin
					if (sts.out_free) begin
						cnt_q <= '0;
						vld_q <= '0;
						drop_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= NW'(in_data.from_node);
			y_q   <= NW'(in_data.to_node);
			cap_q <= in_data.capacity;
			ok_q  <= add_ok;
		end
		unique case (st) inside
			ST_SOLVE: total_q <= '0;
			ST_BFS_E: lvl_u_q <= lv_rd;
			ST_BFS_V, ST_DFS_EDGE: begin
				v_q    <= tgt_rd;
				rc_q   <= r_rd;
				link_q <= link_rd;
			end
			ST_DFS_INIT: begin
				f_node_q <= SRC;
				f_flow_q <= PASS_BUDGET;
				f_res_q  <= '0;
			end
			ST_PUSH2: f_edge_q <= first_eff;
			ST_DFS_TOP: begin
				if (sts.pop) begin
					amt_q <= f_res_q;
					// pass finished: add its flow, saturating
					if (sts.last_frame) total_q <= total_sum[FLOW_W] ? '1 : total_sum[FLOW_W-1:0];
				end
			end
			ST_DFS_LVL: begin
				if (sts.admit && sts.to_sink) begin
					amt_q <= amt;
				end else if (fr_we) begin
					f_node_q <= v_q;
					f_flow_q <= amt;
					f_res_q  <= '0;
				end else begin
					f_edge_q <= link_q;
				end
			end
			ST_POP2: begin
				{f_node_q, f_edge_q} <= fpos_rd;
				{f_flow_q, f_res_q}  <= famt_rd;
			end
			ST_CR_B: link_q <= link_rd;
			ST_CR_C: begin
				f_flow_q <= f_flow_q - amt_q;
				f_res_q  <= f_res_q + amt_q;
				f_edge_q <= link_q;
			end
			ST_DONE: if (sts.out_free) out_q <= '{max_flow: total_q, edges_dropped: drop_q};
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Memories
	dmf_ram #(.WIDTH(EPW), .DEPTH(MAX_NODES)) u_first (
		.clk, .we(nf_we), .waddr(nf_waddr), .wdata(nf_wd), .raddr(nf_raddr), .rdata(nf_rd));
	dmf_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_target (
		.clk, .we(e_we), .waddr(e_waddr), .wdata(tgt_wd), .raddr(e_raddr), .rdata(tgt_rd));
	dmf_ram #(.WIDTH(EPW), .DEPTH(MAX_EDGES)) u_link (
		.clk, .we(e_we), .waddr(e_waddr), .wdata(link_wd), .raddr(e_raddr), .rdata(link_rd));
	dmf_ram #(.WIDTH(CAP_W), .DEPTH(MAX_EDGES)) u_resid (
		.clk, .we(r_we), .waddr(r_waddr), .wdata(r_wd), .raddr(r_raddr), .rdata(r_rd));
	dmf_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_level (
		.clk, .we(lv_we), .waddr(lv_waddr), .wdata(lv_wd), .raddr(lv_raddr), .rdata(lv_rd));
	dmf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
		.clk, .we(q_we), .waddr(q_waddr), .wdata(q_wd), .raddr(q_raddr), .rdata(q_rd));
	dmf_ram #(.WIDTH(NW + EPW), .DEPTH(MAX_NODES)) u_fpos (
		.clk, .we(fr_we), .waddr(fr_waddr), .wdata({f_node_q, f_edge_q}),
		.raddr(fr_raddr), .rdata(fpos_rd));
	dmf_ram #(.WIDTH(2 * CAP_W), .DEPTH(MAX_NODES)) u_famt (
		.clk, .we(fr_we), .waddr(fr_waddr), .wdata({f_flow_q, f_res_q}),
		.raddr(fr_raddr), .rdata(famt_rd));
endmodule

@@ src/dinic_max_flow_engine.sv @@
// Top level of the max-flow engine: controller plus datapath.
// Depends on dmf_pkg, dmf_ctrl, dmf_dpath (and dmf_ram below it).
//
// Usage: input transactions carry either an add-edge (command 0) or a solve
// (command 1). An add stores the edge and its zero-capacity reverse twin;
// an edge with a node of 0, above sink_node or past the node store, or one
// that does not fit in the edge store, is dropped and remembered in a flag.
// Each add occupies the block through states ADD1 and ADD2 (first-edge lookups of both nodes
// go through one RAM read port). A solve runs level builds and blocking-flow
// walks on a stack until the sink is unreachable, then sends one output
// transaction (total flow, dropped flag) and empties the graph. Solve time is
// data dependent: each level build starts with a sweep of the level RAM, then
// dequeues nodes and scans their edges; the walk tries edges, pushes frames,
// credits flow to the sink and pops frames.
// in_stall is high whenever the block is busy. The result sits in an output
// register; a new item is taken while it waits, but a following solve holds
// in its final state until out_stall drops. The user must see that sink_node
// is written through cfg_we/cfg_data only while idle; the block does not
// enforce this. Reset empties the graph, clears the flag, sets sink_node to
// 2; no clearing pass is needed.
module dinic_max_flow_engine #(
	parameter int MAX_NODES = dmf_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = dmf_pkg::MAX_EDGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  dmf_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output dmf_pkg::out_item_t         out_data,
	input  logic                       cfg_we,
	input  logic [dmf_pkg::NODE_W-1:0] cfg_data
);
	import dmf_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	dmf_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_command(in_data.command),
		.sts, .cmd, .in_stall
	);

	dmf_dpath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dpath (
		.clk, .arst_n, .cmd, .in_valid, .in_data, .cfg_we, .cfg_data,
		.out_stall, .out_valid, .out_data, .sts
	);

`ifndef SYNTHESIS
	// A result appears only out of the final solve state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.st == ST_DONE))
		else $error("result without finished solve");

	// An accepted add goes straight into edge writing
	a_add_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (in_data.command == CMD_ADD)) |=> (cmd.st == ST_ADD1))
		else $error("add transaction not started");

	// Popping the source frame ends the pass and restarts the level build
	a_pass_end: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.st == ST_DFS_TOP) && sts.pop && sts.last_frame) |=> (cmd.st == ST_BFS_CLR))
		else $error("blocking pass did not return to level build");
`endif
endmodule

@@ test/testbench.sv @@
// Self-checking testbench for dinic_max_flow_engine: directed table, then random graphs.
// A built-in max-flow predictor supplies the expected results. Depends on dmf_pkg and the RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dmf_pkg::*;

	localparam int NODES    = 256;
	localparam int EDGES    = 512;
	localparam int NO_LINK  = EDGES;
	localparam int LVL_NONE = -1;
	localparam longint FLOW_SAT = 64'h7F_FFFF_FFFF;
	localparam longint CYCLE_LIMIT = 20_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [NODE_W-1:0] cfg_data = '0;

	dinic_max_flow_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Predictor state: the graph as the block should hold it
	int          g_target[EDGES];
	int          g_link[EDGES];
	longint      g_resid[EDGES];
	int          g_first[NODES];
	int          g_level[NODES];
	int          g_queue[NODES];
	int          fr_node[NODES];
	int          fr_edge[NODES];
	longint      fr_flow[NODES];
	longint      fr_pushed[NODES];
	int          g_count;
	bit          g_dropped;
	int          g_sink;

	out_item_t   flow_q[$];
	int          errors;
	int          solves_seen;
	int          drops_seen;
	int          items_sent;
	longint      cycles;
	bit          rx_fast;
	bit          hold_req;

	task automatic report(string what);
		errors++;
		$display("ERROR t=%0t: %s", $realtime, what);
	endtask

	function automatic void graph_clear();
		g_count = 0;
		for (int n = 0; n < NODES; n++) g_first[n] = NO_LINK;
	endfunction

	function automatic void edge_add(int x, int y, longint c);
		int e;
		e = g_count;
		if (x < 1 || x > g_sink || y < 1 || y > g_sink || e + 2 > EDGES) begin
			g_dropped = 1'b1;
			return;
		end
		g_target[e] = y; g_resid[e] = c; g_link[e] = g_first[x]; g_first[x] = e;
		g_target[e+1] = x; g_resid[e+1] = 0; g_link[e+1] = g_first[y]; g_first[y] = e + 1;
		g_count = e + 2;
	endfunction

	// BFS levels from the source; stops once the sink is reached
	function automatic bit levels_build(int sink);
		int head, tail, u, v;
		head = 0; tail = 0;
		for (int n = 0; n < NODES; n++) g_level[n] = LVL_NONE;
		g_level[SOURCE_NODE] = 0;
		g_queue[tail++] = SOURCE_NODE;
		while (head < tail) begin
			u = g_queue[head++];
			for (int e = g_first[u]; e < EDGES; e = g_link[e]) begin
				v = g_target[e];
				if (g_resid[e] > 0 && g_level[v] == LVL_NONE) begin
					g_level[v] = g_level[u] + 1;
					if (v == sink) return 1'b1;
					if (tail < NODES) g_queue[tail++] = v;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic void frame_credit(int top, longint amount);
		int e;
		e = fr_edge[top];
		if (amount > 0) begin
			fr_flow[top] -= amount;
			g_resid[e] -= amount;
			g_resid[e ^ 1] += amount;
			fr_pushed[top] += amount;
		end
		fr_edge[top] = g_link[e];
	endfunction

	// One blocking-flow walk on an explicit stack with dead-end pruning
	function automatic longint blocking_walk(int sink);
		int depth, top, u, e, v;
		longint amt, r;
		depth = 1;
		fr_node[0] = SOURCE_NODE; fr_edge[0] = g_first[SOURCE_NODE];
		fr_flow[0] = PASS_BUDGET; fr_pushed[0] = 0;
		forever begin
			top = depth - 1;
			u = fr_node[top];
			e = fr_edge[top];
			if (e >= EDGES || fr_flow[top] == 0) begin
				r = fr_pushed[top];
				if (r == 0) g_level[u] = LVL_NONE;
				depth--;
				if (depth == 0) return r;
				frame_credit(depth - 1, r);
				continue;
			end
			v = g_target[e];
			if (g_resid[e] > 0 && g_level[u] != LVL_NONE && g_level[v] == g_level[u] + 1) begin
				amt = (g_resid[e] < fr_flow[top]) ? g_resid[e] : fr_flow[top];
				if (v == sink) begin
					frame_credit(top, amt);
					continue;
				end
				if (depth < NODES) begin
					fr_node[depth] = v; fr_edge[depth] = g_first[v];
					fr_flow[depth] = amt; fr_pushed[depth] = 0;
					depth++;
					continue;
				end
			end
			fr_edge[top] = g_link[e];
		end
	endfunction

	function automatic out_item_t flow_solve();
		out_item_t res;
		longint total;
		total = 0;
		if (g_sink >= 2 && g_sink < NODES)
			while (levels_build(g_sink)) begin
				total += blocking_walk(g_sink);
				if (total > FLOW_SAT) total = FLOW_SAT;
			end
		res.max_flow = total[FLOW_W-1:0];
		res.edges_dropped = g_dropped;
		graph_clear();
		g_dropped = 1'b0;
		return res;
	endfunction

	// Typed expectations from the directed table override the predictor's value
	bit        typed_pending;
	out_item_t typed_value;

	// Input and config monitor: predict on every accepted transaction
	always @(posedge clk) begin
		out_item_t r;
		if (arst_n && cfg_we) g_sink = cfg_data;
		if (arst_n && in_valid && !in_stall) begin
			if (in_data.command == CMD_SOLVE) begin
				r = flow_solve();
				if (typed_pending) r = typed_value;
				flow_q.push_back(r);
			end else begin
				edge_add(in_data.from_node, in_data.to_node, in_data.capacity);
			end
			typed_pending = 1'b0;
		end
	end

	// Output checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (flow_q.size() == 0) begin
				report("result with none expected");
			end else begin
				want = flow_q.pop_front();
				solves_seen++;
				if (out_data.edges_dropped) drops_seen++;
				if (out_data.max_flow !== want.max_flow)
					report($sformatf("max_flow %0d, expected %0d", out_data.max_flow,
						want.max_flow));
				if (out_data.edges_dropped !== want.edges_dropped)
					report($sformatf("edges_dropped %0b, expected %0b",
						out_data.edges_dropped, want.edges_dropped));
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("dinic_max_flow_engine: mismatch");
			$finish;
		end
	end

	// Receiver: random stall per transaction, one long hold-off on request
	initial begin
		int w;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				w = 20000;
			end else begin
				w = rx_fast ? 0 : $urandom_range(0, 19);
			end
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send_item(logic cmd, int x, int y, longint c, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= '{command: cmd, from_node: x[7:0], to_node: y[7:0], capacity: c[30:0]};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle_and_config(int value);
		in_valid <= 1'b0;
		wait (flow_q.size() == 0);
		repeat (12) @(negedge clk);
		cfg_data <= value[7:0];
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_node(int sink);
		int k;
		k = $urandom_range(0, 99);
		if (k < 3) return 0;
		if (k < 6) return $urandom_range(0, 255);
		if (k < 8 && sink < 255) return sink + 1;
		if (k < 20) return (k & 1) ? SOURCE_NODE : sink;
		return $urandom_range(1, sink);
	endfunction

	function automatic longint pick_cap();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return 0;
		if (k == 1) return 31'h7FFF_FFFF;
		if (k < 4) return {$urandom} & 32'h7FFF_FFFF;
		return $urandom_range(1, 50);
	endfunction

	typedef struct {
		logic   cmd;
		int     x;
		int     y;
		longint c;
		bit     typed;
		longint flow;
		bit     drop;
	} row_t;

	row_t directed[] = '{
		'{CMD_SOLVE, 0,   0,   0,            1, 0,            0},  // empty graph
		'{CMD_ADD,   1,   2,   31'h7FFFFFFF, 0, 0,            0},
		'{CMD_SOLVE, 255, 255, 31'h7FFFFFFF, 1, 31'h7FFFFFFF, 0},  // max capacity
		'{CMD_ADD,   0,   2,   5,            0, 0,            0},  // node zero
		'{CMD_ADD,   1,   3,   5,            0, 0,            0},  // above sink
		'{CMD_ADD,   255, 2,   5,            0, 0,            0},
		'{CMD_ADD,   1,   1,   9,            0, 0,            0},  // self loop
		'{CMD_ADD,   2,   1,   7,            0, 0,            0},  // wrong way
		'{CMD_ADD,   1,   2,   0,            0, 0,            0},  // zero capacity
		'{CMD_SOLVE, 0,   0,   0,            1, 0,            1},
		'{CMD_ADD,   1,   2,   3,            0, 0,            0},  // duplicates
		'{CMD_ADD,   1,   2,   4,            0, 0,            0},
		'{CMD_SOLVE, 0,   0,   0,            1, 7,            0},
		'{CMD_ADD,   1,   2,   31'h7FFFFFFF, 0, 0,            0},
		'{CMD_ADD,   1,   2,   31'h7FFFFFFF, 0, 0,            0},
		'{CMD_ADD,   2,   2,   31'h7FFFFFFF, 0, 0,            0},
		'{CMD_SOLVE, 0,   0,   0,            1, 64'hFFFFFFFE, 0}
	};

	// Main stimulus
	initial begin
		int sink, nset, gap_max, phase, fill;
		errors = 0; solves_seen = 0; drops_seen = 0; items_sent = 0; cycles = 0;
		rx_fast = 1'b0; hold_req = 1'b0; typed_pending = 1'b0;
		g_sink = SINK_RESET; g_dropped = 1'b0;
		graph_clear();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			typed_pending = directed[i].typed;
			typed_value.max_flow = directed[i].flow[FLOW_W-1:0];
			typed_value.edges_dropped = directed[i].drop;
			send_item(directed[i].cmd, directed[i].x, directed[i].y, directed[i].c,
				$urandom_range(0, 3));
		end

		// Random phases, each with its own sink and pacing
		phase = 0;
		while (items_sent < 1600) begin
			case (phase % 4)
				0: sink = 255;
				1: sink = 2;
				2: sink = $urandom_range(3, 12);
				default: sink = $urandom_range(2, 255);
			endcase
			settle_and_config(sink);
			rx_fast = ($urandom_range(0, 3) == 0);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
			for (int s = 0; s < 6; s++) begin
				fill = (phase % 4 == 0 && s == 0);
				nset = fill ? 300 : $urandom_range(1, 30);
				if (phase == 1 && s == 1) hold_req = 1'b1;
				for (int k = 0; k < nset; k++)
					send_item(CMD_ADD, pick_node(sink), pick_node(sink), pick_cap(),
						$urandom_range(0, gap_max));
				send_item(CMD_SOLVE, $urandom_range(0, 255), $urandom_range(0, 255),
					{$urandom} & 32'h7FFF_FFFF, $urandom_range(0, gap_max));
			end
			phase++;
		end
		in_valid <= 1'b0;

		wait (flow_q.size() == 0);
		repeat (50) @(posedge clk);
		$display("Covered %0d input transactions over %0d sink settings.", items_sent, phase);
		$display("Checked %0d solve results, %0d with dropped edges.", solves_seen, drops_seen);
		if (errors == 0) begin
			$display("dinic_max_flow_engine: match");
		end else begin
			$display("dinic_max_flow_engine: mismatch");
		end
		$finish;
	end
endmodule
